// File: rtl/core/slcd_pkg.sv
// Shared constants, types and the CRC-8 step for the sync/length channel deframer.
package slcd_pkg;

   localparam int NUM_CHANNELS  = 16;
   localparam int PAYLOAD_BYTES = 2 * NUM_CHANNELS;
   localparam int ADDR_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 16;
   localparam int CH_W      = 4;
   localparam int VAL_W     = 11;
   localparam int CSR_IDX_W = 2;

   localparam logic [BYTE_W-1:0] CRC_POLY          = 8'hD5;
   localparam logic [VAL_W-1:0]  VALUE_MAX         = 11'd2047;
   localparam logic [LEN_W-1:0]  CHANNEL_FRAME_LEN = LEN_W'(PAYLOAD_BYTES + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_TYPE  = 2'd2;

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'h55;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'hAA;
   localparam logic [BYTE_W-1:0] FRAME_TYPE_RESET  = 8'h01;

   // controller -> datapath
   typedef struct packed {
      logic len_lo_ld;
      logic len_hi_ld;
      logic body_ld;
      logic emit_start;
      logic emit_load;
   } slcd_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic sync_first_hit;
      logic sync_second_hit;
      logic body_end;
      logic frame_ok;
      logic out_free;
      logic last_ch;
   } slcd_status_type;

   // one byte of CRC-8, MSB first, no reflection
   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// File: rtl/core/slcd_if.sv
// Valid/ready channel interfaces for received bytes and channel results.
interface slcd_req_if import slcd_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcd_rsp_if import slcd_pkg::*;;
   logic             valid;
   logic             ready;
   logic [CH_W-1:0]  channel_index;
   logic [VAL_W-1:0] channel_value;
   logic             last_channel;

   modport source (output valid, output channel_index, output channel_value,
                   output last_channel, input ready);
   modport sink (input valid, input channel_index, input channel_value,
                 input last_channel, output ready);
endinterface

// File: rtl/core/sync_length_crc8_channel_deframer_top.sv
// Top level of the sync/length/type frame parser with CRC-8 check and channel read-out.
//
// Received bytes enter on req_ch, one word per handshake. The parser hunts for
// the two sync bytes, takes a little-endian 16-bit length, the type and body
// bytes and a trailing CRC-8 (poly 0xD5, init 0) computed over the type and body bytes.
// While parsing, ready stays high, so one word is taken every cycle that req_ch offers one.
// A frame with good CRC, the channel type and a 32-byte payload produces 16
// words on rsp_ch (index, value clamped to 2047, last mark on channel 15);
// every other frame is dropped with no output.
// Once the CRC byte is taken, each channel goes through a store read and a
// result register load, and req_ch is held off for the whole read-out.
// A stall on rsp_ch holds the read-out; the last word may wait in the result
// register while the next frame is already being parsed.
// csr_wr_en writes sync_first (0), sync_second (1) or channel_frame_type (2).
// Reset restores 0x55, 0xAA and type 1 and returns to hunting; the payload
// store is not cleared and needs no clearing pass.
module sync_length_crc8_channel_deframer_top import slcd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   slcd_req_if.sink             req_ch,
   slcd_rsp_if.source           rsp_ch,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wr_data
);

   slcd_cmd_type    cmd;
   slcd_status_type status;
   logic            req_ready;
   logic            rsp_valid;
   logic [CH_W-1:0]  channel_index;
   logic [VAL_W-1:0] channel_value;
   logic            last_channel;

   slcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   slcd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .rx_byte       (req_ch.rx_byte),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .cmd           (cmd),
      .status        (status),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_valid),
      .channel_index (channel_index),
      .channel_value (channel_value),
      .last_channel  (last_channel)
   );

   assign req_ch.ready         = req_ready;
   assign rsp_ch.valid         = rsp_valid;
   assign rsp_ch.channel_index = channel_index;
   assign rsp_ch.channel_value = channel_value;
   assign rsp_ch.last_channel  = last_channel;

endmodule

// File: rtl/core/slcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module slcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/slcd_dp.sv
// Datapath: config registers, length/type/CRC tracking, payload store and result register.
module slcd_dp import slcd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [BYTE_W-1:0]    rx_byte,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_wr_data,
   input  slcd_cmd_type         cmd,
   output slcd_status_type      status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [CH_W-1:0]      channel_index,
   output logic [VAL_W-1:0]     channel_value,
   output logic                 last_channel
);

   logic [BYTE_W-1:0] sync_first_ff, sync_first_in;
   logic [BYTE_W-1:0] sync_second_ff, sync_second_in;
   logic [BYTE_W-1:0] frame_type_ff, frame_type_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic [BYTE_W-1:0] kind_ff, kind_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] crc_ff, crc_in;
   logic [ADDR_W-1:0] ch_ff, ch_in;
   logic              out_valid_ff, out_valid_in;
   logic [CH_W-1:0]   out_index_ff, out_index_in;
   logic [VAL_W-1:0]  out_value_ff, out_value_in;
   logic              out_last_ff, out_last_in;

   logic [LEN_W-1:0]  slot;
   logic [LEN_W-1:0]  next_pos;
   logic              slot_in_store;
   logic              even_we, odd_we;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] even_rd, odd_rd;
   logic [2*BYTE_W-1:0] pair;
   logic [VAL_W-1:0]  clamped;

   // payload byte 2i goes to the even store, 2i+1 to the odd store, both at address i
   assign slot          = pos_ff - LEN_W'(1);
   assign next_pos      = pos_ff + LEN_W'(1);
   assign slot_in_store = (pos_ff != '0) && (slot < LEN_W'(PAYLOAD_BYTES));
   assign wr_addr       = slot[ADDR_W:1];
   assign even_we       = cmd.body_ld && slot_in_store && !slot[0];
   assign odd_we        = cmd.body_ld && slot_in_store && slot[0];

   slcd_ram #(.WIDTH(BYTE_W), .DEPTH(NUM_CHANNELS)) u_even_ram (
      .clock   (clock),
      .wr_en   (even_we),
      .wr_addr (wr_addr),
      .wr_data (rx_byte),
      .rd_addr (ch_ff),
      .rd_data (even_rd)
   );

   slcd_ram #(.WIDTH(BYTE_W), .DEPTH(NUM_CHANNELS)) u_odd_ram (
      .clock   (clock),
      .wr_en   (odd_we),
      .wr_addr (wr_addr),
      .wr_data (rx_byte),
      .rd_addr (ch_ff),
      .rd_data (odd_rd)
   );

   assign pair    = {odd_rd, even_rd};
   assign clamped = (pair > (2*BYTE_W)'(VALUE_MAX)) ? VALUE_MAX : pair[VAL_W-1:0];

   always_comb begin
      status.sync_first_hit  = (rx_byte == sync_first_ff);
      status.sync_second_hit = (rx_byte == sync_second_ff);
      status.body_end        = (next_pos >= length_ff);
      status.frame_ok        = (crc_ff == rx_byte) && (kind_ff == frame_type_ff) &&
                               (length_ff == CHANNEL_FRAME_LEN);
      status.out_free        = !out_valid_ff || rsp_ready;
      status.last_ch         = (ch_ff == ADDR_W'(NUM_CHANNELS - 1));
   end

   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      frame_type_in  = frame_type_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SYNC_FIRST:  sync_first_in  = csr_wr_data;
            CSR_SYNC_SECOND: sync_second_in = csr_wr_data;
            CSR_FRAME_TYPE:  frame_type_in  = csr_wr_data;
            default: ;
         endcase
      end

      length_in = length_ff;
      kind_in   = kind_ff;
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      if (cmd.len_lo_ld) begin
         length_in = {{(LEN_W-BYTE_W){1'b0}}, rx_byte};
      end
      if (cmd.len_hi_ld) begin
         length_in = {rx_byte, length_ff[BYTE_W-1:0]};
         pos_in    = '0;
         crc_in    = '0;
      end
      if (cmd.body_ld) begin
         if (pos_ff == '0) begin
            kind_in = rx_byte;
         end
         crc_in = crc8_update(crc_ff, rx_byte);
         pos_in = next_pos;
      end

      ch_in = ch_ff;
      if (cmd.emit_start) begin
         ch_in = '0;
      end else if (cmd.emit_load && !status.last_ch) begin
         ch_in = ch_ff + ADDR_W'(1);
      end

      out_valid_in = out_valid_ff && !rsp_ready;
      out_index_in = out_index_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit_load) begin
         out_valid_in = 1'b1;
         out_index_in = CH_W'(ch_ff);
         out_value_in = clamped;
         out_last_in  = status.last_ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RESET;
         sync_second_ff <= SYNC_SECOND_RESET;
         frame_type_ff  <= FRAME_TYPE_RESET;
         length_ff      <= '0;
         kind_ff        <= '0;
         pos_ff         <= '0;
         crc_ff         <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
         frame_type_ff  <= frame_type_in;
         length_ff      <= length_in;
         kind_ff        <= kind_in;
         pos_ff         <= pos_in;
         crc_ff         <= crc_in;
         out_valid_ff   <= out_valid_in;
      end
      ch_ff        <= ch_in;
      out_index_ff <= out_index_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign channel_index = out_index_ff;
   assign channel_value = out_value_ff;
   assign last_channel  = out_last_ff;

endmodule

// File: rtl/core/slcd_ctrl.sv
// Controller: frame parse phases and the channel read-out sequence.
module slcd_ctrl import slcd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  slcd_status_type status,
   output slcd_cmd_type    cmd
);

   localparam logic [2:0] ST_SYNC_A  = 3'd0;
   localparam logic [2:0] ST_SYNC_B  = 3'd1;
   localparam logic [2:0] ST_LEN_LO  = 3'd2;
   localparam logic [2:0] ST_LEN_HI  = 3'd3;
   localparam logic [2:0] ST_BODY    = 3'd4;
   localparam logic [2:0] ST_CHECK   = 3'd5;
   localparam logic [2:0] ST_EMIT_RD = 3'd6;
   localparam logic [2:0] ST_EMIT_LD = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff != ST_EMIT_RD) && (state_ff != ST_EMIT_LD);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_SYNC_A: begin
            if (accept) begin
               state_in = status.sync_first_hit ? ST_SYNC_B : ST_SYNC_A;
            end
         end
         ST_SYNC_B: begin
            // a wrong second sync byte is not retried as a first one
            if (accept) begin
               state_in = status.sync_second_hit ? ST_LEN_LO : ST_SYNC_A;
            end
         end
         ST_LEN_LO: begin
            if (accept) begin
               cmd.len_lo_ld = 1'b1;
               state_in      = ST_LEN_HI;
            end
         end
         ST_LEN_HI: begin
            if (accept) begin
               cmd.len_hi_ld = 1'b1;
               state_in      = ST_BODY;
            end
         end
         ST_BODY: begin
            // zero length still takes the type byte here
            if (accept) begin
               cmd.body_ld = 1'b1;
               if (status.body_end) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (accept) begin
               if (status.frame_ok) begin
                  cmd.emit_start = 1'b1;
                  state_in       = ST_EMIT_RD;
               end else begin
                  state_in = ST_SYNC_A;
               end
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               state_in      = status.last_ch ? ST_SYNC_A : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_SYNC_A;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SYNC_A;
      end else begin
         state_ff <= state_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> status.out_free)
      else $error("result register loaded while a word is still pending");

   a_start_reads: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_start |=> (state_ff == ST_EMIT_RD) && !req_ready)
      else $error("read-out did not start after a good frame");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_load && status.last_ch) |=> (state_ff == ST_SYNC_A) && req_ready)
      else $error("parser did not resume after the last channel");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.len_lo_ld, cmd.len_hi_ld, cmd.body_ld, cmd.emit_start, cmd.emit_load}))
      else $error("more than one datapath command at once");

endmodule

// File: bench/tb.sv
// Self-checking bench for the sync/length CRC-8 channel deframer: byte driver, word monitor.
module tb;
   import slcd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 160;
   localparam int unsigned READOUT_WAIT = 40;

   typedef enum logic [2:0] {
      HUNT_FIRST, HUNT_SECOND, LEN_LOW, LEN_HIGH, BODY, CRC_CHECK
   } parse_type;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_EDGE} fill_type;

   typedef struct packed {
      logic [CH_W-1:0]  idx;
      logic [VAL_W-1:0] val;
      logic             last;
   } chan_word_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BYTE_W-1:0]    csr_wr_data;

   slcd_req_if req_ch ();
   slcd_rsp_if rsp_ch ();

   sync_length_crc8_channel_deframer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // register copies held by the bench
   logic [7:0] cfg_sync_first  = SYNC_FIRST_RESET;
   logic [7:0] cfg_sync_second = SYNC_SECOND_RESET;
   logic [7:0] cfg_frame_type  = FRAME_TYPE_RESET;

   // parser shadow state
   parse_type   phase = HUNT_FIRST;
   logic [15:0] flen  = '0;
   logic [7:0]  fkind = '0;
   logic [15:0] fpos  = '0;
   logic [7:0]  fcrc  = '0;
   logic [7:0]  chan_bytes [PAYLOAD_BYTES];

   logic [7:0]    rx_backlog [$];
   chan_word_type channels_due [$];
   chan_word_type due_word;
   int unsigned bytes_queued = 0;
   int unsigned words_taken = 0;
   int unsigned hold_words = 0;
   int unsigned hold_left = 0;
   int unsigned mismatches = 0;
   int unsigned cycles = 0;
   bit          steady = 1'b0;

   always #5 clock = ~clock;

   function automatic logic [7:0] crc_d5_next(input logic [7:0] crc, input logic [7:0] d);
      logic [7:0] r;
      logic       fb;
      r = crc;
      for (int k = 7; k >= 0; k--) begin
         fb = r[7] ^ d[k];
         r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   // advance the shadow parser by one accepted word
   task automatic parse_rx_byte(input logic [7:0] b);
      logic [15:0]   pair;
      chan_word_type w;
      case (phase)
         HUNT_SECOND: phase = (b == cfg_sync_second) ? LEN_LOW : HUNT_FIRST;
         LEN_LOW: begin
            flen = {8'h00, b};
            phase = LEN_HIGH;
         end
         LEN_HIGH: begin
            flen[15:8] = b;
            fpos = '0;
            fcrc = '0;
            phase = BODY;
         end
         BODY: begin
            if (fpos == 16'd0) fkind = b;
            else if (fpos <= PAYLOAD_BYTES) chan_bytes[fpos - 16'd1] = b;
            fcrc = crc_d5_next(fcrc, b);
            fpos = fpos + 16'd1;
            if (fpos >= flen) phase = CRC_CHECK;
         end
         CRC_CHECK: begin
            if (b == fcrc && fkind == cfg_frame_type && flen == CHANNEL_FRAME_LEN) begin
               for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                  pair = {chan_bytes[2*ch+1], chan_bytes[2*ch]};
                  w.idx = ch[CH_W-1:0];
                  w.val = (pair > VALUE_MAX) ? VALUE_MAX : pair[VAL_W-1:0];
                  w.last = (ch == NUM_CHANNELS - 1);
                  channels_due.push_back(w);
               end
            end
            phase = HUNT_FIRST;
         end
         default: phase = (b == cfg_sync_first) ? HUNT_SECOND : HUNT_FIRST;
      endcase
   endtask

   task automatic offer(input logic [7:0] b);
      rx_backlog.push_back(b);
      bytes_queued++;
   endtask

   // sync, length, type, payload, CRC; cut drops words from the tail
   task automatic queue_frame(input logic [7:0] kind, input logic [15:0] len,
                              input fill_type fill, input bit bad_crc,
                              input int unsigned cut);
      logic [7:0]  frame [$];
      logic [7:0]  crc;
      logic [7:0]  b;
      logic [15:0] edge_val;
      int unsigned p;
      frame.push_back(cfg_sync_first);
      frame.push_back(cfg_sync_second);
      frame.push_back(len[7:0]);
      frame.push_back(len[15:8]);
      frame.push_back(kind);
      crc = crc_d5_next(8'h00, kind);
      for (int unsigned i = 1; i < len; i++) begin
         p = (i - 1) / 2;
         case (fill)
            FILL_ZERO: b = 8'h00;
            FILL_ONES: b = 8'hFF;
            FILL_EDGE: begin
               case (p % 4)
                  0: edge_val = 16'h07FF;
                  1: edge_val = 16'h0800;
                  2: edge_val = 16'h0000;
                  default: edge_val = 16'hFFFF;
               endcase
               b = (i % 2 == 1) ? edge_val[7:0] : edge_val[15:8];
            end
            default: begin
               // mostly in range, sometimes well over the clamp
               if (i % 2 == 1 || $urandom_range(3) == 0) b = 8'($urandom_range(255));
               else b = 8'($urandom_range(7));
            end
         endcase
         frame.push_back(b);
         crc = crc_d5_next(crc, b);
      end
      frame.push_back(bad_crc ? crc ^ 8'($urandom_range(1, 255)) : crc);
      for (int unsigned i = 0; i + cut < frame.size(); i++) offer(frame[i]);
   endtask

   task automatic queue_random_traffic(input int unsigned goal);
      int unsigned stop_at;
      int unsigned pick;
      int unsigned n;
      logic [15:0] odd_len;
      logic [7:0]  b;
      stop_at = bytes_queued + goal;
      while (bytes_queued < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 66)
            queue_frame(cfg_frame_type, CHANNEL_FRAME_LEN, FILL_RANDOM, 1'b0, 0);
         else if (pick < 74)
            queue_frame(cfg_frame_type, CHANNEL_FRAME_LEN, FILL_RANDOM, 1'b1, 0);
         else if (pick < 80)
            queue_frame(cfg_frame_type ^ 8'($urandom_range(1, 255)), CHANNEL_FRAME_LEN,
                        FILL_RANDOM, 1'b0, 0);
         else if (pick < 86) begin
            odd_len = 16'($urandom_range(45));
            if (odd_len == CHANNEL_FRAME_LEN) odd_len++;
            queue_frame(cfg_frame_type, odd_len, FILL_RANDOM, 1'b0, 0);
         end else if (pick < 91) begin
            offer(cfg_sync_first);
            offer(cfg_sync_second ^ 8'($urandom_range(1, 255)));
         end else if (pick < 96)
            queue_frame(cfg_frame_type, CHANNEL_FRAME_LEN, FILL_RANDOM, 1'b0,
                        $urandom_range(1, 30));
         else begin
            for (n = $urandom_range(1, 6); n > 0; n--) begin
               b = 8'($urandom_range(255));
               // keep most noise from opening a false frame
               if (b == cfg_sync_first && $urandom_range(7) != 0) b = ~b;
               offer(b);
            end
         end
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_SYNC_FIRST:  cfg_sync_first = val;
         CSR_SYNC_SECOND: cfg_sync_second = val;
         CSR_FRAME_TYPE:  cfg_frame_type = val;
         default: ;
      endcase
   endtask

   task automatic wait_for_quiet();
      do @(negedge clock);
      while (rx_backlog.size() != 0 || req_ch.valid || channels_due.size() != 0);
      repeat (READOUT_WAIT) @(negedge clock);
   endtask

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) parse_rx_byte(req_ch.rx_byte);
         if (!req_ch.valid || req_ch.ready) begin
            if (rx_backlog.size() != 0 && (steady || $urandom_range(99) >= 16)) begin
               req_ch.valid   <= 1'b1;
               req_ch.rx_byte <= rx_backlog.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long back-pressure so the read-out stalls and input backs up
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            hold_words <= hold_words + 1;
            if (hold_words == 0 || hold_words == 39) hold_left <= HOLD_CYCLES;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   // channel word monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (channels_due.size() == 0) begin
               report_mismatch($sformatf("word %0d with nothing due: channel %0d value %0d",
                                         words_taken, rsp_ch.channel_index,
                                         rsp_ch.channel_value));
            end else begin
               due_word = channels_due.pop_front();
               if (rsp_ch.channel_index !== due_word.idx)
                  report_mismatch($sformatf("word %0d channel_index %0d, want %0d",
                                            words_taken, rsp_ch.channel_index, due_word.idx));
               if (rsp_ch.channel_value !== due_word.val)
                  report_mismatch($sformatf("word %0d channel_value %0d, want %0d",
                                            words_taken, rsp_ch.channel_value, due_word.val));
               if (rsp_ch.last_channel !== due_word.last)
                  report_mismatch($sformatf("word %0d last_channel %0b, want %0b",
                                            words_taken, rsp_ch.last_channel, due_word.last));
            end
            words_taken++;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= 16);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.rx_byte = '0;
      rsp_ch.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset register values, directed frames
      queue_frame(cfg_frame_type, CHANNEL_FRAME_LEN, FILL_EDGE, 1'b0, 0);
      queue_frame(cfg_frame_type, 16'd0, FILL_RANDOM, 1'b0, 0);
      // payload runs past the store
      queue_frame(cfg_frame_type, 16'd35, FILL_RANDOM, 1'b0, 0);
      // a wrong second sync must not be taken as a new first sync
      offer(cfg_sync_first);
      offer(cfg_sync_first);
      offer(cfg_sync_second);
      queue_frame(cfg_frame_type, CHANNEL_FRAME_LEN, FILL_RANDOM, 1'b0, 0);
      wait_for_quiet();

      // low/high extremes, no random idling on either side
      steady = 1'b1;
      csr_write(CSR_SYNC_FIRST, 8'h00);
      csr_write(CSR_SYNC_SECOND, 8'hFF);
      csr_write(CSR_FRAME_TYPE, 8'hFF);
      queue_frame(cfg_frame_type, CHANNEL_FRAME_LEN, FILL_EDGE, 1'b0, 0);
      queue_random_traffic(30);
      wait_for_quiet();
      steady = 1'b0;

      csr_write(CSR_SYNC_FIRST, 8'hFF);
      csr_write(CSR_SYNC_SECOND, 8'h00);
      csr_write(CSR_FRAME_TYPE, 8'h00);
      queue_frame(cfg_frame_type, CHANNEL_FRAME_LEN, FILL_ONES, 1'b0, 0);
      wait_for_quiet();

      // both sync words equal
      csr_write(CSR_SYNC_FIRST, 8'h3C);
      csr_write(CSR_SYNC_SECOND, 8'h3C);
      csr_write(CSR_FRAME_TYPE, 8'($urandom_range(255)));
      queue_random_traffic(12);
      wait_for_quiet();

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/slcd_pkg.sv
rtl/core/slcd_if.sv
rtl/core/slcd_ram.sv
rtl/core/slcd_dp.sv
rtl/core/slcd_ctrl.sv
rtl/core/sync_length_crc8_channel_deframer_top.sv
bench/tb.sv
